>>> rtl/assert_macros.svh
// Assertion helpers for the merge block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define KWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define KWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/kwm_pkg.sv
`default_nettype none

package kwm_pkg;

  // Sequence count, a power of two for the min tree.
  localparam int MAX_SEQ = 8;
  localparam int IDX_W   = $clog2(MAX_SEQ);
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 4;
  localparam int ACT_W   = $clog2(MAX_SEQ + 1);
  localparam int SEQ_RESET = 8;

  // Item kinds on the input channel
  localparam logic ITEM_NEXT = 1'b0;
  localparam logic ITEM_DONE = 1'b1;

  // Config register index
  localparam logic REG_SEQ_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    RK_ELEMENT = 2'd0,
    RK_FINISH  = 2'd1,
    RK_ERROR   = 2'd2
  } kind_t;

  typedef enum logic {
    ST_ACCEPT,
    ST_EVAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;         // apply accepted item to the marks
    logic post_error;   // load error result
    logic post_result;  // load min or finish result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic misdirected;
    logic all_ready;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/kwm_if.sv
`default_nettype none

// Input channel: one beat per item
interface kwm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [kwm_pkg::IDX_W-1:0]            sequence_index;
  logic signed [kwm_pkg::VALUE_W-1:0]   element_value;

  modport source (output valid, kind, sequence_index, element_value, input ready);
  modport sink   (input valid, kind, sequence_index, element_value, output ready);
endinterface

// Result channel: one beat per result
interface kwm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           result_kind;
  logic signed [kwm_pkg::VALUE_W-1:0]   merged_value;
  logic [kwm_pkg::IDX_W-1:0]            source_sequence;

  modport source (output valid, result_kind, merged_value, source_sequence, input ready);
  modport sink   (input valid, result_kind, merged_value, source_sequence, output ready);
endinterface

`default_nettype wire

>>> rtl/kwm_ctrl.sv
`default_nettype none

module kwm_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  kwm_pkg::status_t  status,
  output logic              in_ready,
  output kwm_pkg::cmd_t     cmd
);

  kwm_pkg::state_t state, state_next;
  logic            accept;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    accept     = 1'b0;
    cmd        = '0;
    unique case (state)
      kwm_pkg::ST_ACCEPT: begin
        // only take a beat when the result register can hold its answer
        in_ready        = status.out_free;
        accept          = in_valid && status.out_free;
        cmd.take        = accept && !status.misdirected;
        cmd.post_error  = accept && status.misdirected;
        if (cmd.take) begin
          state_next = kwm_pkg::ST_EVAL;
        end
      end
      kwm_pkg::ST_EVAL: begin
        // heads settled: emit only once every sequence in use is valid or done
        cmd.post_result = status.all_ready;
        state_next      = kwm_pkg::ST_ACCEPT;
      end
      default: begin
        state_next = kwm_pkg::ST_ACCEPT;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/kwm_datapath.sv
`default_nettype none

module kwm_datapath (
  input  wire                                clk,
  input  wire                                rst,
  // item payload
  input  wire                                item_kind,
  input  wire [kwm_pkg::IDX_W-1:0]           item_index,
  input  wire signed [kwm_pkg::VALUE_W-1:0]  item_value,
  // config
  input  wire                                cfg_write,
  input  wire                                cfg_sel,
  input  wire [kwm_pkg::CNT_W-1:0]           cfg_data,
  output logic [kwm_pkg::CNT_W-1:0]          seq_count,
  // control
  input  kwm_pkg::cmd_t                      cmd,
  output kwm_pkg::status_t                   status,
  kwm_out_if.source                          merged
);

  localparam int NODES = 2 * kwm_pkg::MAX_SEQ;

  logic signed [kwm_pkg::VALUE_W-1:0] heads [kwm_pkg::MAX_SEQ];
  logic [kwm_pkg::MAX_SEQ-1:0]        head_valid;
  logic [kwm_pkg::MAX_SEQ-1:0]        seq_done;
  logic [kwm_pkg::MAX_SEQ-1:0]        in_use;
  logic [kwm_pkg::ACT_W-1:0]          active_n;

  logic                               out_valid;
  kwm_pkg::kind_t                     out_kind;
  logic signed [kwm_pkg::VALUE_W-1:0] out_value;
  logic [kwm_pkg::IDX_W-1:0]          out_src;

  // min tree, heap order: node 1 is the root, leaves from MAX_SEQ up
  logic                               node_ok  [NODES];
  logic signed [kwm_pkg::VALUE_W-1:0] node_val [NODES];
  logic [kwm_pkg::IDX_W-1:0]          node_idx [NODES];

  logic [kwm_pkg::IDX_W-1:0]          best;
  logic                               any_valid;

  // clamp the register to 1 .. MAX_SEQ
  always_comb begin
    if (seq_count == '0) begin
      active_n = kwm_pkg::ACT_W'(1);
    end else if (int'(seq_count) > kwm_pkg::MAX_SEQ) begin
      active_n = kwm_pkg::ACT_W'(kwm_pkg::MAX_SEQ);
    end else begin
      active_n = kwm_pkg::ACT_W'(seq_count);
    end
    for (int i = 0; i < kwm_pkg::MAX_SEQ; i++) begin
      in_use[i] = int'(active_n) > i;
    end
  end

  // status towards the controller
  assign status.misdirected = !in_use[item_index] || head_valid[item_index]
                              || seq_done[item_index];
  assign status.all_ready   = &(head_valid | seq_done | ~in_use);
  assign status.out_free    = !out_valid || merged.ready;

  // three-level min tree; on a tie the left (lower index) side wins
  always_comb begin
    node_ok[0]  = 1'b0;
    node_val[0] = '0;
    node_idx[0] = '0;
    for (int i = 0; i < kwm_pkg::MAX_SEQ; i++) begin
      node_ok[kwm_pkg::MAX_SEQ + i]  = head_valid[i] && in_use[i];
      node_val[kwm_pkg::MAX_SEQ + i] = heads[i];
      node_idx[kwm_pkg::MAX_SEQ + i] = kwm_pkg::IDX_W'(i);
    end
    for (int n = kwm_pkg::MAX_SEQ - 1; n >= 1; n--) begin
      if (node_ok[2*n+1] && (!node_ok[2*n] || node_val[2*n+1] < node_val[2*n])) begin
        node_ok[n]  = 1'b1;
        node_val[n] = node_val[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_ok[n]  = node_ok[2*n];
        node_val[n] = node_val[2*n];
        node_idx[n] = node_idx[2*n];
      end
    end
  end

  assign any_valid = node_ok[1];
  assign best      = node_idx[1];

  // control state: config, marks, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_count  <= kwm_pkg::CNT_W'(kwm_pkg::SEQ_RESET);
      head_valid <= '0;
      seq_done   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write && cfg_sel == kwm_pkg::REG_SEQ_IN_USE) begin
        seq_count <= cfg_data;
      end
      if (merged.valid && merged.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.take) begin
        if (item_kind == kwm_pkg::ITEM_NEXT) begin
          head_valid[item_index] <= 1'b1;
        end else begin
          seq_done[item_index] <= 1'b1;
        end
      end
      if (cmd.post_error) begin
        out_valid <= 1'b1;
      end
      if (cmd.post_result) begin
        out_valid <= 1'b1;
        if (any_valid) begin
          head_valid[best] <= 1'b0;
        end else begin
          head_valid <= '0;
          seq_done   <= '0;
        end
      end
    end
  end

  // payload: head values and result register
  always_ff @(posedge clk) begin
    if (cmd.take && item_kind == kwm_pkg::ITEM_NEXT) begin
      heads[item_index] <= item_value;
    end
    if (cmd.post_error) begin
      out_kind  <= kwm_pkg::RK_ERROR;
      out_value <= '0;
      out_src   <= item_index;
    end else if (cmd.post_result) begin
      if (any_valid) begin
        out_kind  <= kwm_pkg::RK_ELEMENT;
        out_value <= node_val[1];
        out_src   <= best;
      end else begin
        out_kind  <= kwm_pkg::RK_FINISH;
        out_value <= '0;
        out_src   <= '0;
      end
    end
  end

  assign merged.valid           = out_valid;
  assign merged.result_kind     = out_kind;
  assign merged.merged_value    = out_value;
  assign merged.source_sequence = out_src;

endmodule

`default_nettype wire

>>> rtl/k_way_sorted_merge.sv
`default_nettype none

// Channel   Dir  Beat contents
// items     in   kind, sequence_index, element_value
// merged    out  result_kind, merged_value, source_sequence
// apb       in   sequences_in_use at byte address 0
//
// A misdirected item's beat loads an error result; any other beat updates
// the marks, then the next cycle runs the 8-way min tree over the registered
// heads and loads the result register if every sequence in use is valid or done.
// Reset clears all marks and sets sequences_in_use to 8; no clearing pass.
// items.ready drops during the evaluate cycle and while a result waits
// in the output register without merged.ready.

module k_way_sorted_merge (
  input  wire         clk,
  input  wire         rst,
  kwm_in_if.sink      items,
  kwm_out_if.source   merged,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kwm_pkg::cmd_t              cmd;
  kwm_pkg::status_t           status;
  logic [kwm_pkg::CNT_W-1:0]  seq_count;
  logic                       cfg_write;

  // APB: zero wait states, register 0 at byte 0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == kwm_pkg::REG_SEQ_IN_USE)
                     ? {{(32 - kwm_pkg::CNT_W){1'b0}}, seq_count} : '0;

  kwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .status   (status),
    .in_ready (items.ready),
    .cmd      (cmd)
  );

  kwm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_kind  (items.kind),
    .item_index (items.sequence_index),
    .item_value (items.element_value),
    .cfg_write  (cfg_write),
    .cfg_sel    (paddr[2]),
    .cfg_data   (pwdata[kwm_pkg::CNT_W-1:0]),
    .seq_count  (seq_count),
    .cmd        (cmd),
    .status     (status),
    .merged     (merged)
  );

endmodule

`default_nettype wire

>>> rtl/kwm_checker.sv
`default_nettype none
`include "assert_macros.svh"

module kwm_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire [1:0]                          out_kind,
  input wire signed [kwm_pkg::VALUE_W-1:0]  out_value,
  input wire [kwm_pkg::IDX_W-1:0]           out_src
);

  // no result is pending straight after reset
  `KWM_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // only the three defined result kinds appear
  `KWM_ASSERT(a_kind_legal, out_valid |-> (out_kind == kwm_pkg::RK_ELEMENT || out_kind == kwm_pkg::RK_FINISH || out_kind == kwm_pkg::RK_ERROR), "undefined result kind")

  // finish beat carries zero value and source zero
  `KWM_ASSERT(a_finish_zero, (out_valid && out_kind == kwm_pkg::RK_FINISH) |-> (out_value == '0 && out_src == '0), "finish beat not zeroed")

  // a stalled result holds
  `KWM_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_src) && $stable(out_kind)), "stalled result changed")

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (merged.valid),
  .out_ready (merged.ready),
  .out_kind  (merged.result_kind),
  .out_value (merged.merged_value),
  .out_src   (merged.source_sequence)
);

`default_nettype wire

>>> verif/tb_k_way_sorted_merge.sv
`timescale 1ns / 100ps

module tb_k_way_sorted_merge;

  // one result beat as the block should present it
  typedef struct packed {
    kwm_pkg::kind_t                     rk;
    logic signed [kwm_pkg::VALUE_W-1:0] value;
    logic [kwm_pkg::IDX_W-1:0]          src;
  } merge_out_t;

  // Tracks heads, valid and done marks, and the results still owed
  class merge_checker;
    logic [kwm_pkg::CNT_W-1:0]          count_reg;
    logic signed [kwm_pkg::VALUE_W-1:0] heads [kwm_pkg::MAX_SEQ];
    bit                                 head_valid [kwm_pkg::MAX_SEQ];
    bit                                 seq_done [kwm_pkg::MAX_SEQ];
    merge_out_t                         due_results [$];
    int unsigned                        mismatches;
    int unsigned                        items_taken;
    int unsigned                        elements_seen;
    int unsigned                        finishes_seen;
    int unsigned                        errors_seen;

    function new();
      count_reg = kwm_pkg::CNT_W'(kwm_pkg::SEQ_RESET);
      for (int i = 0; i < kwm_pkg::MAX_SEQ; i++) begin
        heads[i] = '0;
        head_valid[i] = 1'b0;
        seq_done[i] = 1'b0;
      end
    endfunction

    function void set_count(logic [kwm_pkg::CNT_W-1:0] v);
      count_reg = v;
    endfunction

    // 0 behaves as 1, anything past the maximum as the maximum
    function int unsigned clamp_count(logic [kwm_pkg::CNT_W-1:0] v);
      if (v < 1) return 1;
      if (v > kwm_pkg::MAX_SEQ) return kwm_pkg::MAX_SEQ;
      return v;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function bit needy(int i);
      return (i < clamp_count(count_reg)) && !head_valid[i] && !seq_done[i];
    endfunction

    function bit fresh();
      for (int i = 0; i < kwm_pkg::MAX_SEQ; i++)
        if (head_valid[i] || seq_done[i]) return 1'b0;
      return 1'b1;
    endfunction

    // lowest sequence that is neither holding a head nor done
    function int first_gap();
      for (int i = 0; i < kwm_pkg::MAX_SEQ; i++)
        if (!head_valid[i] && !seq_done[i]) return i;
      return kwm_pkg::MAX_SEQ;
    endfunction

    // apply an accepted item beat and queue any result it causes
    function void take_item(logic kind, logic [kwm_pkg::IDX_W-1:0] idx,
                            logic signed [kwm_pkg::VALUE_W-1:0] value);
      int unsigned n;
      int          best;
      bit          found;
      merge_out_t  r;
      n = clamp_count(count_reg);
      items_taken++;
      if (idx >= n || head_valid[idx] || seq_done[idx]) begin
        r.rk = kwm_pkg::RK_ERROR;
        r.value = '0;
        r.src = idx;
        due_results = {due_results, r};
        return;
      end
      if (kind == kwm_pkg::ITEM_NEXT) begin
        heads[idx] = value;
        head_valid[idx] = 1'b1;
      end else begin
        seq_done[idx] = 1'b1;
      end
      // still waiting on some sequence in use
      for (int i = 0; i < n; i++)
        if (!head_valid[i] && !seq_done[i]) return;
      // smallest head, ties to the lowest index
      found = 1'b0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        if (head_valid[i] && (!found || heads[i] < heads[best])) begin
          found = 1'b1;
          best = i;
        end
      end
      if (found) begin
        head_valid[best] = 1'b0;
        r.rk = kwm_pkg::RK_ELEMENT;
        r.value = heads[best];
        r.src = kwm_pkg::IDX_W'(best);
      end else begin
        for (int i = 0; i < kwm_pkg::MAX_SEQ; i++) begin
          head_valid[i] = 1'b0;
          seq_done[i] = 1'b0;
        end
        r.rk = kwm_pkg::RK_FINISH;
        r.value = '0;
        r.src = '0;
      end
      due_results = {due_results, r};
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // compare one result beat with the oldest owed result
    task check_beat(logic [1:0] rk, logic signed [kwm_pkg::VALUE_W-1:0] value,
                    logic [kwm_pkg::IDX_W-1:0] src);
      merge_out_t r;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing owed: kind %0d value %0d source %0d",
                         rk, value, src));
        return;
      end
      r = due_results.pop_front();
      if (rk !== r.rk)
        report($sformatf("result_kind %0d, wanted %0d", rk, r.rk));
      if (value !== r.value)
        report($sformatf("merged_value %0d, wanted %0d", value, r.value));
      if (src !== r.src)
        report($sformatf("source_sequence %0d, wanted %0d", src, r.src));
      case (r.rk)
        kwm_pkg::RK_ELEMENT: elements_seen++;
        kwm_pkg::RK_FINISH:  finishes_seen++;
        default:             errors_seen++;
      endcase
    endtask
  endclass

  localparam longint VAL_MAX = (longint'(1) <<< (kwm_pkg::VALUE_W - 1)) - 1;
  localparam longint VAL_MIN = -(longint'(1) <<< (kwm_pkg::VALUE_W - 1));

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kwm_in_if  items ();
  kwm_out_if merged ();

  merge_checker sb = new();

  // values still to offer per sequence in the current merge
  logic signed [kwm_pkg::VALUE_W-1:0] feed_q [kwm_pkg::MAX_SEQ][$];
  logic [kwm_pkg::CNT_W-1:0]          count_plan [7] = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd9,
                                                         4'd2, 4'd5};
  bit                                 no_stall;
  int unsigned                        count_writes;

  k_way_sorted_merge DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .merged  (merged),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // time limit
  initial begin
    #5_000_000;
    $display("run stalled: time limit reached with %0d results owed", sb.pending());
    $display("tb: failure");
    $finish;
  end

  // result side: check each beat, stall at random
  initial begin
    merged.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && merged.valid && merged.ready)
        sb.check_beat(merged.result_kind, merged.merged_value, merged.source_sequence);
      merged.ready <= no_stall || ($urandom_range(0, 99) >= 25);
    end
  end

  // APB write of the sequence count; upper data bits are don't-care
  task automatic write_count(input logic [kwm_pkg::CNT_W-1:0] v);
    logic [31:0] pad;
    pad = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {kwm_pkg::REG_SEQ_IN_USE, 2'b00};
    pwdata  <= {pad[31:kwm_pkg::CNT_W], v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_count(v);
    count_writes++;
  endtask

  // drive one item beat, with random idle cycles ahead of it
  task automatic send(input logic k, input logic [kwm_pkg::IDX_W-1:0] idx,
                      input logic signed [kwm_pkg::VALUE_W-1:0] v);
    while (!no_stall && $urandom_range(0, 99) < 25) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid          <= 1'b1;
    items.kind           <= k;
    items.sequence_index <= idx;
    items.element_value  <= v;
    do @(posedge clk); while (!items.ready);
    sb.take_item(k, idx, v);
  endtask

  // wait for every owed result, then let the block go quiet
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // new ascending sequences, mostly short, a few long or scrambled
  function automatic void refill();
    longint v;
    int     len;
    int     mode;
    bit     scramble;
    for (int i = 0; i < kwm_pkg::MAX_SEQ; i++) begin
      feed_q[i].delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      scramble = ($urandom_range(0, 9) == 0);
      mode = $urandom_range(0, 3);
      case (mode)
        0:       v = VAL_MIN + $urandom_range(0, 3);
        1:       v = longint'($urandom_range(0, 40)) - 20;
        2:       v = longint'($signed($urandom));
        default: v = VAL_MAX - $urandom_range(0, 30);
      endcase
      for (int j = 0; j < len; j++) begin
        if (scramble) feed_q[i] = {feed_q[i], $urandom};
        else feed_q[i] = {feed_q[i], v[kwm_pkg::VALUE_W-1:0]};
        if ($urandom_range(0, 2) != 0)
          v += (mode == 2) ? $urandom_range(1, 1 << 24) : $urandom_range(1, 4);
        if (v > VAL_MAX) v = VAL_MAX;
      end
    end
  endfunction

  // feed the sequence the block waits on; now and then a stray beat
  task automatic feed_one();
    int                                 needy [$];
    int                                 stray [$];
    int                                 pick;
    logic                               k;
    logic signed [kwm_pkg::VALUE_W-1:0] v;
    if (sb.fresh()) refill();
    for (int i = 0; i < kwm_pkg::MAX_SEQ; i++) begin
      if (sb.needy(i)) needy = {needy, i};
      else stray = {stray, i};
    end
    if (needy.size() == 0 || (stray.size() != 0 && $urandom_range(0, 99) < 8)) begin
      pick = stray[$urandom_range(0, stray.size() - 1)];
      k = $urandom_range(0, 1);
      v = $urandom;
    end else begin
      pick = needy[$urandom_range(0, needy.size() - 1)];
      if (feed_q[pick].size() == 0) begin
        k = kwm_pkg::ITEM_DONE;
        v = $urandom;
      end else begin
        k = kwm_pkg::ITEM_NEXT;
        v = feed_q[pick].pop_front();
      end
    end
    send(k, kwm_pkg::IDX_W'(pick), v);
  endtask

  // next count: must keep some waiting sequence in use
  function automatic logic [kwm_pkg::CNT_W-1:0] pick_count(int step);
    logic [kwm_pkg::CNT_W-1:0] c;
    c = (step < 7) ? count_plan[step] : kwm_pkg::CNT_W'($urandom_range(0, 15));
    while (sb.clamp_count(c) <= sb.first_gap()) c = kwm_pkg::CNT_W'($urandom_range(0, 15));
    return c;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned lot;
    int          step;
    rst                  <= 1'b1;
    items.valid          <= 1'b0;
    items.kind           <= kwm_pkg::ITEM_NEXT;
    items.sequence_index <= '0;
    items.element_value  <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    no_stall = 1'b0;
    count_writes = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: three sequences, extremes, ties, strays, out-of-order input
    write_count(4'd3);
    send(kwm_pkg::ITEM_NEXT, 3'd5, 32'sd77);           // sequence not in use
    send(kwm_pkg::ITEM_NEXT, 3'd0, 32'sh7FFF_FFFF);
    send(kwm_pkg::ITEM_NEXT, 3'd0, 32'sd1);            // head already held
    send(kwm_pkg::ITEM_NEXT, 3'd1, 32'sh8000_0000);
    send(kwm_pkg::ITEM_NEXT, 3'd2, 32'sh8000_0000);    // tie, lower index wins
    send(kwm_pkg::ITEM_DONE, 3'd1, 32'shFFFF_FFFF);
    send(kwm_pkg::ITEM_DONE, 3'd1, 32'sd0);            // already done
    send(kwm_pkg::ITEM_NEXT, 3'd2, 32'sd0);
    send(kwm_pkg::ITEM_DONE, 3'd2, 32'sd0);
    send(kwm_pkg::ITEM_DONE, 3'd0, 32'sd0);            // finish
    send(kwm_pkg::ITEM_NEXT, 3'd0, 32'sd5);
    send(kwm_pkg::ITEM_NEXT, 3'd1, -32'sd1);
    send(kwm_pkg::ITEM_NEXT, 3'd2, 32'sd5);
    send(kwm_pkg::ITEM_NEXT, 3'd1, -32'sd100);         // below the previous value
    send(kwm_pkg::ITEM_DONE, 3'd1, 32'sd0);
    send(kwm_pkg::ITEM_DONE, 3'd0, 32'sd0);
    send(kwm_pkg::ITEM_DONE, 3'd2, 32'sd0);
    send(kwm_pkg::ITEM_DONE, 3'd7, 32'sh8000_0000);    // not in use
    items.valid <= 1'b0;
    settle();
    write_count(4'd8);

    // random merges in lots; count changes between lots, often mid-merge
    sent = 0;
    step = 0;
    while (sent < 1600) begin
      lot = $urandom_range(40, 200);
      no_stall = (sent >= 700 && sent < 1000);
      repeat (lot) begin
        feed_one();
        sent++;
      end
      items.valid <= 1'b0;
      no_stall = 1'b0;
      settle();
      write_count(pick_count(step));
      step++;
    end

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("run covered %0d item beats over %0d sequence-count writes",
             sb.items_taken, count_writes);
    $display("results checked: %0d merged elements, %0d finishes, %0d misdirected items",
             sb.elements_seen, sb.finishes_seen, sb.errors_seen);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
